// ----- src/tcp_conntrack_state_tracker_top_macros.svh -----
// Assertion macros for the TCP connection tracking state tracker.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TCP_CONNTRACK_STATE_TRACKER_TOP_MACROS_SVH
`define TCP_CONNTRACK_STATE_TRACKER_TOP_MACROS_SVH

// Check that holds while out of reset.
`define TCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also holds across reset.
`define TCT_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/tct_pkg.sv -----
// Package for the TCP connection tracking state tracker: state codes,
// flag ranks, table entry layout, transition and timeout tables. No dependencies.
package tct_pkg;

  localparam int CONNECTIONS = 1024;
  localparam int IDX_W       = $clog2(CONNECTIONS);

  typedef enum logic [3:0] {
    ST_NONE    = 4'd0,
    ST_ES      = 4'd1,
    ST_SS      = 4'd2,
    ST_SR      = 4'd3,
    ST_FW      = 4'd4,
    ST_TW      = 4'd5,
    ST_CL      = 4'd6,
    ST_CW      = 4'd7,
    ST_LA      = 4'd8,
    ST_LI      = 4'd9,
    ST_INVALID = 4'd10
  } tcp_state_t;

  typedef enum logic [2:0] {
    RANK_SYN  = 3'd0,
    RANK_FIN  = 3'd1,
    RANK_ACK  = 3'd2,
    RANK_RST  = 3'd3,
    RANK_NONE = 3'd4
  } flag_rank_t;

  typedef enum logic {
    CTL_CLEAR = 1'b0,
    CTL_RUN   = 1'b1
  } ctl_state_t;

  typedef struct packed {
    tcp_state_t  state;
    logic [31:0] hs_word;
    logic        assured;
  } conn_entry_t;

  typedef struct packed {
    logic        kind;
    logic        is_reply;
    logic        syn_flag;
    logic        fin_flag;
    logic        ack_flag;
    logic        rst_flag;
    logic [31:0] seq;
    logic [31:0] ack_seq;
    logic        seen_reply;
  } pkt_req_t;

  localparam logic [18:0] TMO_30_MIN = 19'd1800;
  localparam logic [18:0] TMO_5_DAY  = 19'd432000;
  localparam logic [18:0] TMO_2_MIN  = 19'd120;
  localparam logic [18:0] TMO_60_SEC = 19'd60;
  localparam logic [18:0] TMO_10_SEC = 19'd10;
  localparam logic [18:0] TMO_30_SEC = 19'd30;

  // Rows per direction: syn, fin, ack, rst, none; columns: old state.
  localparam tcp_state_t NEXT_TAB [2][5][10] = '{
    '{
      '{ST_SS, ST_ES, ST_SS, ST_SR, ST_SS, ST_SS, ST_SS, ST_SS, ST_SS, ST_LI},
      '{ST_TW, ST_FW, ST_SS, ST_TW, ST_FW, ST_TW, ST_CL, ST_TW, ST_LA, ST_LI},
      '{ST_ES, ST_ES, ST_SS, ST_ES, ST_FW, ST_TW, ST_CL, ST_CW, ST_LA, ST_ES},
      '{ST_CL, ST_CL, ST_SS, ST_CL, ST_CL, ST_TW, ST_CL, ST_CL, ST_CL, ST_CL},
      '{ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID,
        ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID}
    },
    '{
      '{ST_SR, ST_ES, ST_SR, ST_SR, ST_SR, ST_SR, ST_SR, ST_SR, ST_SR, ST_SR},
      '{ST_CL, ST_CW, ST_SS, ST_TW, ST_TW, ST_TW, ST_CL, ST_CW, ST_LA, ST_LI},
      '{ST_CL, ST_ES, ST_SS, ST_SR, ST_FW, ST_TW, ST_CL, ST_CW, ST_CL, ST_LI},
      '{ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_LA, ST_LI},
      '{ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID,
        ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID, ST_INVALID}
    }
  };

  function automatic flag_rank_t flag_rank(input logic syn, input logic fin,
                                           input logic ack, input logic rst);
    priority if (rst) return RANK_RST;
    else if (syn)     return RANK_SYN;
    else if (fin)     return RANK_FIN;
    else if (ack)     return RANK_ACK;
    else              return RANK_NONE;
  endfunction

  function automatic tcp_state_t next_state(input logic dir, input flag_rank_t rank,
                                            input tcp_state_t old);
    if (rank == RANK_NONE || old > ST_LI) return ST_INVALID;
    return NEXT_TAB[dir][rank][old];
  endfunction

  function automatic logic [18:0] state_timeout(input tcp_state_t st);
    unique case (st)
      ST_NONE: return TMO_30_MIN;
      ST_ES:   return TMO_5_DAY;
      ST_SS:   return TMO_2_MIN;
      ST_SR:   return TMO_60_SEC;
      ST_FW:   return TMO_2_MIN;
      ST_TW:   return TMO_2_MIN;
      ST_CL:   return TMO_10_SEC;
      ST_CW:   return TMO_60_SEC;
      ST_LA:   return TMO_30_SEC;
      ST_LI:   return TMO_2_MIN;
      default: return 19'd0;
    endcase
  endfunction

endpackage

// ----- src/tcp_conntrack_state_tracker_top.sv -----
// Top level of the TCP connection tracking state tracker: connection table
// memory, read-modify-write pipeline, output register. Uses tct_pkg and the macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per packet header or
//   new-connection start; output channel (out_valid/out_ready) returns one
//   result per request, in order.
//   Throughput: one request per cycle while the receiver keeps up. The table
//   is one synchronous memory read at accept and written back as the request
//   leaves the read stage; a request that hits the entry being written in the
//   same cycle takes the written value through a forwarding register, so
//   back-to-back requests to one connection need no gap.
//   out_valid rises once the read-stage request is loaded into the output register.
//   Reset: rst_n low clears control state; afterwards a clearing pass writes
//   every table entry to NONE / zero / not assured, one entry a cycle, over all
//   CONNECTIONS (1024) entries, during which in_ready stays low.
//   Stall: when out_valid is high and out_ready low, the result holds, the
//   request in the read stage holds, and, if that stage is full, in_ready
//   drops until the result is taken. Removing a deleted entry is left to the caller.
`include "tcp_conntrack_state_tracker_top_macros.svh"

module tcp_conntrack_state_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [9:0]  in_conn_id,
  input  logic        in_is_reply,
  input  logic        in_syn_flag,
  input  logic        in_fin_flag,
  input  logic        in_ack_flag,
  input  logic        in_rst_flag,
  input  logic [31:0] in_seq,
  input  logic [31:0] in_ack_seq,
  input  logic        in_seen_reply,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_invalid,
  output logic [3:0]  out_new_state,
  output logic [18:0] out_timeout_seconds,
  output logic        out_delete_now,
  output logic        out_assured
);

  // Connection table: one word per connection.
  tct_pkg::conn_entry_t mem [tct_pkg::CONNECTIONS];

  // Control: clearing pass, then run.
  tct_pkg::ctl_state_t             ctl_state_r, ctl_state_nxt;
  logic [tct_pkg::IDX_W-1:0]       clr_addr_r, clr_addr_nxt;

  // Read stage: request waiting for its table word.
  logic                            s1_valid_r;
  tct_pkg::pkt_req_t               s1_req_r;
  logic [tct_pkg::IDX_W-1:0]       s1_idx_r;
  tct_pkg::conn_entry_t            rd_data_r;
  logic                            fwd_hit_r;
  tct_pkg::conn_entry_t            fwd_data_r;

  // Output register.
  logic                            out_valid_r;
  logic                            out_invalid_r;
  tct_pkg::tcp_state_t             out_state_r;
  logic [18:0]                     out_tmo_r;
  logic                            out_del_r;
  logic                            out_assured_r;

  // Combinational.
  logic                            in_fire;
  logic                            s1_go;
  logic [tct_pkg::IDX_W-1:0]       in_idx;
  logic                            wr_en;
  logic [tct_pkg::IDX_W-1:0]       wr_idx;
  tct_pkg::conn_entry_t            wr_data;
  tct_pkg::conn_entry_t            cur;
  tct_pkg::conn_entry_t            upd;
  tct_pkg::flag_rank_t             rank;
  tct_pkg::tcp_state_t             old_st;
  tct_pkg::tcp_state_t             nxt_st;
  logic                            dir;
  logic                            trans_bad;
  logic                            del;
  logic [18:0]                     tmo;

  assign in_idx   = tct_pkg::IDX_W'(in_conn_id % tct_pkg::CONNECTIONS);
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = (ctl_state_r == tct_pkg::CTL_RUN) && (!s1_valid_r || s1_go);
  assign in_fire  = in_valid && in_ready;

  // Controller: sweep the table once after reset, then run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_state_r <= tct_pkg::CTL_CLEAR;
      clr_addr_r  <= '0;
    end else begin
      ctl_state_r <= ctl_state_nxt;
      clr_addr_r  <= clr_addr_nxt;
    end
  end

  always_comb begin
    ctl_state_nxt = ctl_state_r;
    clr_addr_nxt  = clr_addr_r;
    unique case (ctl_state_r)
      tct_pkg::CTL_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == tct_pkg::IDX_W'(tct_pkg::CONNECTIONS - 1)) begin
          ctl_state_nxt = tct_pkg::CTL_RUN;
        end
      end
      tct_pkg::CTL_RUN: begin
        clr_addr_nxt = clr_addr_r;
      end
      default: begin
        ctl_state_nxt = tct_pkg::CTL_CLEAR;
      end
    endcase
  end

  // Transition logic on the word read for the request in the read stage.
  always_comb begin
    cur       = fwd_hit_r ? fwd_data_r : rd_data_r;
    rank      = tct_pkg::flag_rank(s1_req_r.syn_flag, s1_req_r.fin_flag,
                                   s1_req_r.ack_flag, s1_req_r.rst_flag);
    dir       = s1_req_r.kind ? 1'b0 : s1_req_r.is_reply;
    old_st    = s1_req_r.kind ? tct_pkg::ST_NONE : cur.state;
    nxt_st    = tct_pkg::next_state(dir, rank, old_st);
    trans_bad = (nxt_st == tct_pkg::ST_INVALID);
    upd       = cur;
    upd.state = nxt_st;
    del       = 1'b0;
    tmo       = 19'd0;
    if (s1_req_r.kind) begin
      upd.hs_word = '0;
      upd.assured = 1'b0;
    end else begin
      // Reply SYN+ACK in SS: record the expected handshake ack.
      if (old_st == tct_pkg::ST_SS && dir && s1_req_r.syn_flag && s1_req_r.ack_flag) begin
        upd.hs_word = s1_req_r.seq + 32'd1;
      end
      if (!s1_req_r.seen_reply && s1_req_r.rst_flag) begin
        del = 1'b1;
      end else begin
        // Original-side ACK completing the handshake: mark assured.
        if (old_st == tct_pkg::ST_SR && !dir && s1_req_r.ack_flag &&
            !s1_req_r.syn_flag && s1_req_r.ack_seq == upd.hs_word) begin
          upd.assured = 1'b1;
        end
        tmo = tct_pkg::state_timeout(nxt_st);
      end
    end
  end

  // Single write port: clearing pass or write-back of a valid transition.
  always_comb begin
    if (ctl_state_r == tct_pkg::CTL_CLEAR) begin
      wr_en   = 1'b1;
      wr_idx  = clr_addr_r;
      wr_data = '{state: tct_pkg::ST_NONE, hs_word: 32'd0, assured: 1'b0};
    end else begin
      wr_en   = s1_go && !trans_bad;
      wr_idx  = s1_idx_r;
      wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read at accept; capture the word being written this cycle if it is the same entry.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r  <= mem[in_idx];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= wr_en && (wr_idx == in_idx);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r <= in_idx;
      s1_req_r <= '{kind: in_kind, is_reply: in_is_reply, syn_flag: in_syn_flag,
                    fin_flag: in_fin_flag, ack_flag: in_ack_flag, rst_flag: in_rst_flag,
                    seq: in_seq, ack_seq: in_ack_seq, seen_reply: in_seen_reply};
    end
  end

  // Output register: load on advance, drop valid when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_invalid_r <= trans_bad;
      out_state_r   <= trans_bad ? cur.state : nxt_st;
      out_tmo_r     <= trans_bad ? 19'd0 : tmo;
      out_del_r     <= trans_bad ? 1'b0 : del;
      out_assured_r <= trans_bad ? cur.assured : upd.assured;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_invalid         = out_invalid_r;
  assign out_new_state       = 4'(out_state_r);
  assign out_timeout_seconds = out_tmo_r;
  assign out_delete_now      = out_del_r;
  assign out_assured         = out_assured_r;

  `TCT_ASSERT(a_no_accept_in_clear, (ctl_state_r == tct_pkg::CTL_CLEAR) |-> !in_ready, "request accepted during clearing pass")
  `TCT_ASSERT(a_wr_source, wr_en |-> (ctl_state_r == tct_pkg::CTL_CLEAR || s1_go), "table write without a source")
  `TCT_ASSERT(a_fwd_capture, (in_fire && wr_en && wr_idx == in_idx) |=> fwd_hit_r, "same-entry write not forwarded")
  `TCT_ASSERT(a_stall_cause, (s1_valid_r && !s1_go) |-> (out_valid_r && !out_ready), "read stage held without output stall")
  `TCT_ASSERT_ANY(a_reset_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
